@@ rtl/rrc_pkg.sv @@
// ----------------------------------------------------------------------------
// rrc_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int CoordW   = 20;
  localparam int SizeW    = 16;
  localparam int AngW     = 15;
  localparam int Steps    = 16;
  localparam int TrigW    = 32;
  localparam int ZW       = 24;
  localparam int QueueDepth = 4;

  localparam logic signed [TrigW-1:0] CordicGain = 32'sd652032874;
  localparam logic signed [AngW-1:0]  Ang45  = 15'sd2880;
  localparam logic signed [AngW-1:0]  Ang135 = 15'sd8640;

  typedef enum logic [1:0] {
    ORIENT_LOW,
    ORIENT_MID,
    ORIENT_HIGH
  } orient_t;

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
    logic signed [ZW-1:0]     z;
    logic                     neg;
    orient_t                  orient;
  } job_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    v = '0;
    case (i)
      0:  v = 24'sd2949120;
      1:  v = 24'sd1740967;
      2:  v = 24'sd919879;
      3:  v = 24'sd466945;
      4:  v = 24'sd234379;
      5:  v = 24'sd117304;
      6:  v = 24'sd58666;
      7:  v = 24'sd29335;
      8:  v = 24'sd14668;
      9:  v = 24'sd7334;
      10: v = 24'sd3667;
      11: v = 24'sd1833;
      12: v = 24'sd917;
      13: v = 24'sd458;
      14: v = 24'sd229;
      15: v = 24'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/rrc_front.sv @@
// ----------------------------------------------------------------------------
// rrc_front
// accepts rectangles, reduces the angle and classifies the corner order
// ----------------------------------------------------------------------------
module rrc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [87:0]          in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrc_pkg::job_t        out_job
);

  logic signed [rrc_pkg::AngW-1:0] ang;
  logic signed [rrc_pkg::AngW+1:0] m;
  logic signed [rrc_pkg::AngW+1:0] r;
  logic                            neg;
  rrc_pkg::job_t                   job;

  assign ang = in_data[86:72];

  always_comb begin
    m = {{2{ang[rrc_pkg::AngW-1]}}, ang};
    if (m > 17'sd11520) m = m - 17'sd23040;
    neg = 1'b0;
    r = m;
    if (m > 17'sd5760) begin
      r = m - 17'sd11520;
      neg = 1'b1;
    end else if (m < -17'sd5760) begin
      r = m + 17'sd11520;
      neg = 1'b1;
    end
    job.cx  = in_data[19:0];
    job.cy  = in_data[39:20];
    job.w   = in_data[55:40];
    job.h   = in_data[71:56];
    job.z   = {r[rrc_pkg::ZW-11:0], 10'd0};
    job.neg = neg;
    if (ang < rrc_pkg::Ang45) job.orient = rrc_pkg::ORIENT_LOW;
    else if (ang < rrc_pkg::Ang135) job.orient = rrc_pkg::ORIENT_MID;
    else job.orient = rrc_pkg::ORIENT_HIGH;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_job <= job;
    end
  end

endmodule

@@ rtl/rrc_queue.sv @@
// ----------------------------------------------------------------------------
// rrc_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module rrc_queue #(
  parameter int Depth = rrc_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rrc_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output rrc_pkg::job_t out_job
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  rrc_pkg::job_t   mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign in_ready  = count != (AW+1)'(Depth);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_job;
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(Depth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count lost a pop");

endmodule

@@ rtl/rrc_back.sv @@
// ----------------------------------------------------------------------------
// rrc_back
// pipelined cordic, products and corner rounding, one job per unstalled cycle
// ----------------------------------------------------------------------------
module rrc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrc_pkg::job_t        in_job,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [159:0]         out_data
);

  localparam int N  = rrc_pkg::Steps;
  localparam int TW = rrc_pkg::TrigW;
  localparam int PW = 50;
  localparam int LAT = N + 5;

  logic                     adv;
  logic [LAT-1:0]           vld;
  rrc_pkg::job_t            job [N+1];
  logic signed [TW-1:0]     cx  [N+1];
  logic signed [TW-1:0]     cy  [N+1];
  logic signed [rrc_pkg::ZW-1:0] cz [N+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      job[0] <= in_job;
      cx[0]  <= rrc_pkg::CordicGain;
      cy[0]  <= '0;
      cz[0]  <= in_job.z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        job[i+1] <= job[i];
        if (!cz[i][rrc_pkg::ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - rrc_pkg::atan_entry(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + rrc_pkg::atan_entry(i);
        end
      end
    end
  end

  // products
  rrc_pkg::job_t        jp, js, jc;
  logic signed [PW-1:0] wc, hs, ws, hc;
  logic signed [TW:0]   c, s;
  logic signed [PW-1:0] we, he, ce, se;
  always_comb begin
    c = job[N].neg ? -{cx[N][TW-1], cx[N]} : {cx[N][TW-1], cx[N]};
    s = job[N].neg ? -{cy[N][TW-1], cy[N]} : {cy[N][TW-1], cy[N]};
    we = PW'($signed({1'b0, job[N].w}));
    he = PW'($signed({1'b0, job[N].h}));
    ce = PW'(c);
    se = PW'(s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jp <= job[N];
      wc <= we * ce;
      hs <= he * se;
      ws <= we * se;
      hc <= he * ce;
    end
  end

  logic signed [PW:0] tu, tv, tp, tq;
  always_ff @(posedge clk) begin
    if (adv) begin
      js <= jp;
      tu <= {wc[PW-1], wc} - {hs[PW-1], hs};
      tv <= {ws[PW-1], ws} + {hc[PW-1], hc};
      tp <= {wc[PW-1], wc} + {hs[PW-1], hs};
      tq <= {ws[PW-1], ws} - {hc[PW-1], hc};
    end
  end

  function automatic logic [19:0] corner(input logic signed [19:0] b,
                                         input logic signed [PW:0] t, input logic plus);
    logic signed [55:0] v;
    logic signed [24:0] q;
    v = {{5{b[19]}}, b, 31'd0};
    v = plus ? v + 56'(t) : v - 56'(t);
    v = v + (56'sd1 <<< 30);
    q = 25'(v >>> 31);
    if (q > 25'sd524287) q = 25'sd524287;
    if (q < -25'sd524288) q = -25'sd524288;
    return q[19:0];
  endfunction

  logic [19:0] p [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      jc   <= js;
      p[0] <= corner(js.cx, tu, 1'b0);
      p[1] <= corner(js.cy, tv, 1'b1);
      p[2] <= corner(js.cx, tp, 1'b0);
      p[3] <= corner(js.cy, tq, 1'b1);
      p[4] <= corner(js.cx, tu, 1'b1);
      p[5] <= corner(js.cy, tv, 1'b0);
      p[6] <= corner(js.cx, tp, 1'b1);
      p[7] <= corner(js.cy, tq, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      case (jc.orient)
        rrc_pkg::ORIENT_LOW:
          out_data <= {p[7], p[6], p[5], p[4], p[3], p[2], p[1], p[0]};
        rrc_pkg::ORIENT_MID:
          out_data <= {p[1], p[0], p[7], p[6], p[5], p[4], p[3], p[2]};
        default:
          out_data <= {p[3], p[2], p[1], p[0], p[7], p[6], p[5], p[4]};
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld == $past(vld))
    else $error("pipeline moved while stalled");

endmodule

@@ rtl/rotated_rect_corners.sv @@
// ----------------------------------------------------------------------------
// rotated_rect_corners
// four corners of a rotated rectangle from center, size and angle
// ----------------------------------------------------------------------------
// Takes one rectangle per cycle and returns one beat of corners per cycle.
// The result passes through the front register, the queue write, the cordic
// load register, sixteen cordic stages, and four registers for products,
// sums, rounding and corner order. Throughput is set by the pipelined cordic
// and stays at one beat per clock while the output is taken.
module rotated_rect_corners #(
  parameter int QueueDepth = rrc_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // center_x, center_y, rect_width, rect_height, rect_angle, zero fill
  input  logic [87:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // bl_x, bl_y, tl_x, tl_y, tr_x, tr_y, br_x, br_y
  output logic [159:0] m_tdata
);

  logic          f_valid, f_ready, q_valid, q_ready;
  rrc_pkg::job_t f_job, q_job;

  rrc_front u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .out_valid(f_valid), .out_ready(f_ready), .out_job(f_job)
  );

  rrc_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  rrc_back u_back (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule
